### rtl/core/wrw_pkg.sv
package wrw_pkg;

  localparam logic [24:0] SYNC_CHUNK = 25'd32768;
  localparam logic [24:0] RING_MAX   = 25'd16777216;
  localparam logic [24:0] CAP_RST    = 25'd1048576;
  localparam logic [24:0] LOW_RST    = 25'd262144;
  localparam logic [24:0] HIGH_RST   = 25'd786432;

  localparam logic [2:0] CMD_PUMP     = 3'd0;
  localparam logic [2:0] CMD_READ     = 3'd1;
  localparam logic [2:0] CMD_FETCH    = 3'd2;
  localparam logic [2:0] CMD_SEEK_SET = 3'd3;
  localparam logic [2:0] CMD_SEEK_CUR = 3'd4;
  localparam logic [2:0] CMD_SEEK_END = 3'd5;

  localparam logic [1:0] REG_CAP  = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;

  typedef enum logic [2:0] {
    OP_PUMP, OP_READ, OP_FETCH, OP_SEEK_SET, OP_SEEK_CUR, OP_SEEK_END, OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK, KIND_RUN, KIND_FETCH, KIND_SHORT
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PF_SPACE, S_PF_EVICT, S_PF_MOD, S_PF_LEN,
    S_RD_CHK, S_RD_MOD, S_RD_RUN, S_RD_TAIL, S_FD_MOD, S_FD_UPD, S_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [24:0]        count;
    logic signed [31:0] position;
    logic               seek_failed;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] ring_offset;
    logic [24:0] length;
    logic [31:0] stream_pos;
    logic        seek_needed;
    logic        ok;
    logic [24:0] fill_ahead;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [24:0] count;
    logic [31:0] position;
    logic        failed;
  } qent_t;

  typedef struct packed {
    logic [24:0] cap;
    logic [24:0] low;
    logic [24:0] high;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] x;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] rem;
  } mod_rsp_t;

  function automatic logic [24:0] eff_cap(input logic [24:0] raw);
    logic [24:0] c;
    c = raw;
    if (raw == 25'd0) c = 25'd1;
    else if (raw > RING_MAX) c = RING_MAX;
    return c;
  endfunction

endpackage

### rtl/core/wrw_ifs.sv
interface wrw_in_if;
  logic               valid;
  logic               ready;
  wrw_pkg::in_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface wrw_out_if;
  logic               valid;
  logic               ready;
  wrw_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/watermark_ring_window_controller_core.sv
// Seeks, acks and unknown commands go from dispatch straight to the result; a
// fetch done, a pump fetch and each read run wait on the 32-step serial ring
// modulo unit. A read may give up to two runs and then a fetch.
// The back end takes one request at a time; a 2-entry queue accepts requests.
// Reset (rst_n, synchronous, active low) clears positions and flags, sets fill
// mode and loads the default ring capacity and watermarks.
module watermark_ring_window_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  wrw_in_if.sink      in_ch,
  wrw_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wrw_pkg::*;

  logic [24:0] cap_r, low_r, high_r;
  logic        wr_en;
  cfg_t        cfg;
  logic        q_vld, pop;
  qent_t       q_ent;
  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RST;
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_CAP:  cap_r  <= cfg_pwdata[24:0];
        REG_LOW:  low_r  <= cfg_pwdata[24:0];
        REG_HIGH: high_r <= cfg_pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CAP:  cfg_prdata = {7'd0, cap_r};
      REG_LOW:  cfg_prdata = {7'd0, low_r};
      REG_HIGH: cfg_prdata = {7'd0, high_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.cap  = eff_cap(cap_r);
  assign cfg.low  = low_r;
  assign cfg.high = high_r;

  wrw_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .q_vld (q_vld),
    .q_ent (q_ent)
  );

  wrw_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .cap   (cfg.cap),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  wrw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_vld   (q_vld),
    .q_ent   (q_ent),
    .pop     (pop),
    .mod_req (mod_req),
    .mod_rsp (mod_rsp),
    .out_ch  (out_ch)
  );

endmodule

### rtl/core/wrw_mod.sv
module wrw_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [24:0]       cap,
  input  wrw_pkg::mod_req_t req,
  output wrw_pkg::mod_rsp_t rsp
);
  import wrw_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] x_r, x_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [24:0] trial;

  assign trial = {rem_r[23:0], x_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      x_nxt    = req.x;
      rem_nxt  = 25'd0;
    end else if (busy_r) begin
      rem_nxt = (trial >= cap) ? trial - cap : trial;
      x_nxt   = {x_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[23:0];

endmodule

### rtl/core/wrw_front.sv
module wrw_front (
  input  logic            clk,
  input  logic            rst_n,
  wrw_in_if.sink          in_ch,
  input  logic            pop,
  output logic            q_vld,
  output wrw_pkg::qent_t  q_ent
);
  import wrw_pkg::*;

  qent_t      q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] n_r;
  logic       push, pull;
  qent_t      ent;

  always_comb begin
    ent.count    = in_ch.data.count;
    ent.position = in_ch.data.position;
    ent.failed   = in_ch.data.seek_failed;
    case (in_ch.data.command)
      CMD_PUMP:     ent.op = OP_PUMP;
      CMD_READ:     ent.op = OP_READ;
      CMD_FETCH:    ent.op = OP_FETCH;
      CMD_SEEK_SET: ent.op = OP_SEEK_SET;
      CMD_SEEK_CUR: ent.op = OP_SEEK_CUR;
      CMD_SEEK_END: ent.op = OP_SEEK_END;
      default:      ent.op = OP_BAD;
    endcase
  end

  assign in_ch.ready = (n_r != 2'd2);
  assign push  = in_ch.valid && in_ch.ready;
  assign pull  = pop && (n_r != 2'd0);
  assign q_vld = (n_r != 2'd0);
  assign q_ent = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      n_r      <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pull) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pull) n_r <= n_r + 2'd1;
      else if (pull && !push) n_r <= n_r - 2'd1;
    end
    if (push) q_r[wr_ptr_r] <= ent;
  end

endmodule

### rtl/core/wrw_back.sv
module wrw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wrw_pkg::cfg_t     cfg,
  input  logic              q_vld,
  input  wrw_pkg::qent_t    q_ent,
  output logic              pop,
  output wrw_pkg::mod_req_t mod_req,
  input  wrw_pkg::mod_rsp_t mod_rsp,
  wrw_out_if.source         out_ch
);
  import wrw_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] off;
    logic [24:0] len;
    logic        seekn;
    logic        ok;
    logic        last;
  } res_t;

  bk_state_t   state_r, state_nxt, ret_r, ret_nxt;
  op_t         op_r, op_nxt;
  logic [24:0] cnt_r, cnt_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        fail_r, fail_nxt;
  logic [31:0] ws_r, ws_nxt, wp_r, wp_nxt, rp_r, rp_nxt, bp_r, bp_nxt;
  logic        bk_r, bk_nxt, es_r, es_nxt, bm_r, bm_nxt;
  logic [24:0] space_r, space_nxt, want_r, want_nxt, done_r, done_nxt;
  logic [1:0]  runs_r, runs_nxt;
  res_t        res_r, res_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_r, out_nxt;

  logic [24:0] cap;
  logic [31:0] buffered, ahead, evictable, t;
  logic [24:0] free_sp, contig, need, ev, space_ev, want_cl, pf_len;
  logic [24:0] rem_cnt, take1, take, room, fd_n;
  logic [33:0] tgt;
  logic        neg, inwin, go, bm_pump, out_free, rd_more, rd_last;

  assign cap       = cfg.cap;
  assign buffered  = wp_r - ws_r;
  assign free_sp   = (buffered >= {7'd0, cap}) ? 25'd0 : cap - buffered[24:0];
  assign ahead     = wp_r - rp_r;
  assign contig    = cap - {1'b0, mod_rsp.rem};
  assign evictable = rp_r - ws_r;
  assign need      = want_r - space_r;
  assign ev        = ({7'd0, need} < evictable) ? need : evictable[24:0];
  assign space_ev  = (space_r < want_r) ? space_r + ev : space_r;
  assign want_cl   = (want_r > space_ev) ? space_ev : want_r;
  assign pf_len    = (want_r > contig) ? contig : want_r;
  assign rem_cnt   = cnt_r - done_r;
  assign take1     = ({7'd0, rem_cnt} > ahead) ? ahead[24:0] : rem_cnt;
  assign take      = (take1 > contig) ? contig : take1;
  assign rd_last   = (done_r + take == cnt_r);
  assign rd_more   = (done_r < cnt_r) && (rp_r != wp_r) && (runs_r != 2'd2);
  assign room      = (free_sp > contig) ? contig : free_sp;
  assign fd_n      = (cnt_r > room) ? room : cnt_r;
  assign tgt       = (op_r == OP_SEEK_SET) ? {{2{pos_r[31]}}, pos_r}
                   : {2'd0, rp_r} + {{2{pos_r[31]}}, pos_r};
  assign neg       = tgt[33];
  assign t         = tgt[31:0];
  assign inwin     = (t - ws_r) <= (wp_r - ws_r);
  assign out_free  = !out_vld_r || out_ch.ready;

  always_comb begin
    go      = 1'b0;
    bm_pump = bm_r;
    if (bm_r) begin
      if (es_r || ahead >= {7'd0, cfg.high}) bm_pump = 1'b0;
      else go = 1'b1;
    end else if (!es_r && ahead < {7'd0, cfg.low}) begin
      bm_pump = 1'b1;
      go      = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (q_vld) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (op_r)
          OP_PUMP:  state_nxt = (go && cnt_r != 25'd0) ? S_PF_SPACE : S_EMIT;
          OP_READ:  state_nxt = (cnt_r != 25'd0) ? S_RD_CHK : S_EMIT;
          OP_FETCH: state_nxt = (!fail_r && cnt_r != 25'd0) ? S_FD_MOD : S_EMIT;
          default:  state_nxt = S_EMIT;
        endcase
      end
      S_PF_SPACE: state_nxt = S_PF_EVICT;
      S_PF_EVICT: state_nxt = (space_ev == 25'd0) ? S_EMIT : S_PF_MOD;
      S_PF_MOD:   if (mod_rsp.done) state_nxt = S_PF_LEN;
      S_PF_LEN:   state_nxt = S_EMIT;
      S_RD_CHK:   state_nxt = rd_more ? S_RD_MOD : S_RD_TAIL;
      S_RD_MOD:   if (mod_rsp.done) state_nxt = S_RD_RUN;
      S_RD_RUN:   state_nxt = S_EMIT;
      S_RD_TAIL:  state_nxt = (rp_r == wp_r) ? S_PF_SPACE : S_EMIT;
      S_FD_MOD:   if (mod_rsp.done) state_nxt = S_FD_UPD;
      S_FD_UPD:   state_nxt = S_EMIT;
      S_EMIT:     if (out_free) state_nxt = ret_r;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt      = op_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    fail_nxt    = fail_r;
    ws_nxt      = ws_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    bp_nxt      = bp_r;
    bk_nxt      = bk_r;
    es_nxt      = es_r;
    bm_nxt      = bm_r;
    space_nxt   = space_r;
    want_nxt    = want_r;
    done_nxt    = done_r;
    runs_nxt    = runs_r;
    res_nxt     = res_r;
    ret_nxt     = ret_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    pop         = 1'b0;
    mod_req     = '0;

    case (state_r)
      S_IDLE: begin
        pop = q_vld;
        if (q_vld) begin
          op_nxt   = q_ent.op;
          cnt_nxt  = q_ent.count;
          pos_nxt  = q_ent.position;
          fail_nxt = q_ent.failed;
        end
      end
      S_DISPATCH: begin
        res_nxt = '{kind: KIND_ACK, off: 24'd0, len: 25'd0, seekn: 1'b0,
                    ok: 1'b1, last: 1'b1};
        ret_nxt = S_IDLE;
        case (op_r)
          OP_PUMP: begin
            bm_nxt   = bm_pump;
            want_nxt = cnt_r;
          end
          OP_READ: begin
            done_nxt = 25'd0;
            runs_nxt = 2'd0;
          end
          OP_FETCH: begin
            if (fail_r) begin
              res_nxt.ok = 1'b0;
            end else begin
              bp_nxt = wp_r;
              bk_nxt = 1'b1;
              if (cnt_r == 25'd0) begin
                es_nxt     = 1'b1;
                res_nxt.ok = 1'b0;
              end else begin
                mod_req.start = 1'b1;
                mod_req.x     = wp_r;
              end
            end
          end
          OP_SEEK_SET, OP_SEEK_CUR: begin
            res_nxt.ok = !neg;
            if (!neg) begin
              rp_nxt = t;
              if (!inwin) begin
                ws_nxt = t;
                wp_nxt = t;
                es_nxt = 1'b0;
              end
            end
          end
          OP_SEEK_END: begin
            res_nxt.ok = !fail_r && !pos_r[31];
            if (!fail_r && !pos_r[31]) begin
              bp_nxt = pos_r;
              bk_nxt = 1'b1;
              ws_nxt = pos_r;
              wp_nxt = pos_r;
              rp_nxt = pos_r;
            end
          end
          default: res_nxt.ok = 1'b0;
        endcase
      end
      S_PF_SPACE: space_nxt = free_sp;
      S_PF_EVICT: begin
        if (space_r < want_r) ws_nxt = ws_r + {7'd0, ev};
        space_nxt = space_ev;
        want_nxt  = want_cl;
        ret_nxt   = S_IDLE;
        if (space_ev == 25'd0) begin
          if (op_r == OP_PUMP)
            res_nxt = '{kind: KIND_ACK, off: 24'd0, len: 25'd0, seekn: 1'b0,
                        ok: 1'b1, last: 1'b1};
          else
            res_nxt = '{kind: KIND_SHORT, off: 24'd0, len: done_r, seekn: 1'b0,
                        ok: 1'b0, last: 1'b1};
        end else begin
          mod_req.start = 1'b1;
          mod_req.x     = wp_r;
        end
      end
      S_PF_LEN: begin
        res_nxt = '{kind: KIND_FETCH, off: mod_rsp.rem, len: pf_len,
                    seekn: (!bk_r || bp_r != wp_r), ok: 1'b1, last: 1'b1};
        ret_nxt = S_IDLE;
      end
      S_RD_CHK: begin
        if (rd_more) begin
          mod_req.start = 1'b1;
          mod_req.x     = rp_r;
        end
      end
      S_RD_RUN: begin
        rp_nxt   = rp_r + {7'd0, take};
        done_nxt = done_r + take;
        runs_nxt = runs_r + 2'd1;
        res_nxt  = '{kind: KIND_RUN, off: mod_rsp.rem, len: take, seekn: 1'b0,
                     ok: 1'b1, last: rd_last};
        ret_nxt  = rd_last ? S_IDLE : S_RD_CHK;
      end
      S_RD_TAIL: begin
        want_nxt = SYNC_CHUNK;
        res_nxt  = '{kind: KIND_SHORT, off: 24'd0, len: done_r, seekn: 1'b0,
                     ok: 1'b0, last: 1'b1};
        ret_nxt  = S_IDLE;
      end
      S_FD_UPD: begin
        wp_nxt = wp_r + {7'd0, fd_n};
        bp_nxt = wp_r + {7'd0, fd_n};
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt         = 1'b1;
          out_nxt.kind        = res_r.kind;
          out_nxt.ring_offset = res_r.off;
          out_nxt.length      = res_r.len;
          out_nxt.stream_pos  = (res_r.kind == KIND_FETCH) ? wp_r : rp_r;
          out_nxt.seek_needed = res_r.seekn;
          out_nxt.ok          = res_r.ok;
          out_nxt.fill_ahead  = ahead[24:0];
          out_nxt.last        = res_r.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ws_r      <= 32'd0;
      wp_r      <= 32'd0;
      rp_r      <= 32'd0;
      bp_r      <= 32'd0;
      bk_r      <= 1'b0;
      es_r      <= 1'b0;
      bm_r      <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ws_r      <= ws_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      bp_r      <= bp_nxt;
      bk_r      <= bk_nxt;
      es_r      <= es_nxt;
      bm_r      <= bm_nxt;
      out_vld_r <= out_vld_nxt;
    end
    ret_r   <= ret_nxt;
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    pos_r   <= pos_nxt;
    fail_r  <= fail_nxt;
    space_r <= space_nxt;
    want_r  <= want_nxt;
    done_r  <= done_nxt;
    runs_r  <= runs_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

### rtl/core/wrw_chk.sv
module wrw_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input wrw_pkg::out_item_t  out_data
);
  import wrw_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_RUN |->
      out_data.ok && !out_data.seek_needed && out_data.length != 25'd0)
    else $error("bad data run");

  a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_FETCH |->
      out_data.ok && out_data.last && out_data.length != 25'd0)
    else $error("bad fetch request");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_SHORT |-> !out_data.ok && out_data.last)
    else $error("bad short read");

endmodule

bind watermark_ring_window_controller_core wrw_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
